### rtl/calendar_date_add_subtract_unit_defines.svh
// Assertion macros shared by the calendar date unit RTL.
`ifndef CALENDAR_DATE_ADD_SUBTRACT_UNIT_DEFINES_SVH
`define CALENDAR_DATE_ADD_SUBTRACT_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CDAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date unit: same-cycle check failed");
`define CDAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date unit: next-cycle check failed");
`else
`define CDAS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/cdas_pkg.sv
// Types, constants and calendar tables for the calendar date unit.
package cdas_pkg;

    localparam int YEAR_LIMIT = 9999;
    localparam int ACC_W      = 26;
    localparam int N_W        = 25;
    localparam int YEAR_W     = 14;

    localparam logic signed [ACC_W-1:0] SERIAL_LAST = ACC_W'(365 * YEAR_LIMIT
        + YEAR_LIMIT / 4 - YEAR_LIMIT / 100 + YEAR_LIMIT / 400 - 1);
    localparam logic signed [ACC_W-1:0] MONTH_INDEX_MIN = ACC_W'(12);
    localparam logic signed [ACC_W-1:0] MONTH_INDEX_END = ACC_W'((YEAR_LIMIT + 1) * 12);
    localparam logic signed [ACC_W-1:0] YEAR_MIN_S      = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] YEAR_LIMIT_S    = ACC_W'(YEAR_LIMIT);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [3:0] SER_LAST   = 4'd3;
    localparam logic [3:0] SPLIT_LAST = 4'd13;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic [1:0] KIND_DAYS   = 2'd0;
    localparam logic [1:0] KIND_WEEKS  = 2'd1;
    localparam logic [1:0] KIND_MONTHS = 2'd2;
    localparam logic [1:0] KIND_YEARS  = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [13:0] year_in;
        logic [21:0] amount;
    } req_t;

    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic             subtract;
        logic [ACC_W-1:0] operand;
    } alu_ctl_t;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_SER   = 11'b000_0000_0100,
        S_ADDN  = 11'b000_0000_1000,
        S_RANGE = 11'b000_0001_0000,
        S_MDIV  = 11'b000_0010_0000,
        S_SPLIT = 11'b000_0100_0000,
        S_LEAPW = 11'b000_1000_0000,
        S_MSCAN = 11'b001_0000_0000,
        S_CLAMP = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    // Divisibility by 25 uses the inverse of 25 modulo 2^14 and a bound compare.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = YEAR_W'(y * YEAR_W'(7209));
        div25 = (prod <= YEAR_W'((2**YEAR_W - 1) / 25));
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] cnt;
        case (m)
            4'd1:    cnt = 9'd0;
            4'd2:    cnt = 9'd31;
            4'd3:    cnt = 9'd59;
            4'd4:    cnt = 9'd90;
            4'd5:    cnt = 9'd120;
            4'd6:    cnt = 9'd151;
            4'd7:    cnt = 9'd181;
            4'd8:    cnt = 9'd212;
            4'd9:    cnt = 9'd243;
            4'd10:   cnt = 9'd273;
            4'd11:   cnt = 9'd304;
            4'd12:   cnt = 9'd334;
            default: cnt = 9'd0;
        endcase
        if (leap && (m > MONTH_FEB) && (m <= MONTH_DEC))
        begin
            cnt = cnt + 9'd1;
        end
        return cnt;
    endfunction

    // Restoring split of a day count into 400, 100, 4 and 1 year periods.
    function automatic logic [21:0] split_div(input logic [3:0] k);
        logic [21:0] d;
        case (k)
            4'd0:    d = 22'd2337552;
            4'd1:    d = 22'd1168776;
            4'd2:    d = 22'd584388;
            4'd3:    d = 22'd292194;
            4'd4:    d = 22'd146097;
            4'd5:    d = 22'd73048;
            4'd6:    d = 22'd36524;
            4'd7:    d = 22'd23376;
            4'd8:    d = 22'd11688;
            4'd9:    d = 22'd5844;
            4'd10:   d = 22'd2922;
            4'd11:   d = 22'd1461;
            4'd12:   d = 22'd730;
            4'd13:   d = 22'd365;
            default: d = 22'd0;
        endcase
        return d;
    endfunction

    function automatic logic [YEAR_W-1:0] split_wt(input logic [3:0] k);
        logic [YEAR_W-1:0] w;
        case (k)
            4'd0:    w = 14'd6400;
            4'd1:    w = 14'd3200;
            4'd2:    w = 14'd1600;
            4'd3:    w = 14'd800;
            4'd4:    w = 14'd400;
            4'd5:    w = 14'd200;
            4'd6:    w = 14'd100;
            4'd7:    w = 14'd64;
            4'd8:    w = 14'd32;
            4'd9:    w = 14'd16;
            4'd10:   w = 14'd8;
            4'd11:   w = 14'd4;
            4'd12:   w = 14'd2;
            4'd13:   w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

endpackage

### rtl/cdas_alu.sv
// Shared add and subtract unit of the calendar date sequencer.
module cdas_alu
    import cdas_pkg::*;
(
    input  logic signed [ACC_W-1:0] acc,
    input  alu_ctl_t                ctl,
    output logic signed [ACC_W-1:0] sum
);

    logic signed [ACC_W-1:0] opd;

    assign opd = $signed(ctl.operand);
    assign sum = ctl.subtract ? (acc - opd) : (acc + opd);

endmodule

### rtl/calendar_date_add_subtract_unit.sv
// Top level of the Gregorian calendar date add and subtract unit.
// The done strobe follows a transfer on start and is high for one cycle; rsp holds the result after it.
// Invalid dates and zero amounts go from the check straight to done; other moves add, range-check and clamp.
// Day moves use the shared adder: 4 serial steps, 14 restoring split steps, up to 12 month steps.
// A new request is taken in the cycle after done; rst_n clears the sequencer to idle at once.
`include "calendar_date_add_subtract_unit_defines.svh"

module calendar_date_add_subtract_unit
    import cdas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;

    logic [2:0]        op_reg;
    logic [4:0]        day_reg;
    logic [3:0]        mon_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [N_W-1:0]    n_reg;
    logic              lpin_reg;
    logic              leap_reg;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [YEAR_W-1:0]       qt_reg, qt_next;
    logic [YEAR_W-1:0]       ry_reg, ry_next;
    logic [3:0]              rm_reg, rm_next;
    logic [4:0]              rd_reg, rd_next;
    logic [1:0]              status_reg, status_next;

    alu_ctl_t                alu_ctl;
    logic signed [ACC_W-1:0] alu_sum;

    logic [1:0]        kind;
    logic              sub;
    logic [YEAR_W-1:0] p;
    logic [26:0]       p_mul;
    logic [7:0]        q100;
    logic [22:0]       p365;
    logic [17:0]       y12;
    logic [30:0]       t_mul;
    logic [YEAR_W-1:0] q12;
    logic [9:0]        day_ofs;
    logic [4:0]        ml_in;
    logic [4:0]        ml_res;
    logic              date_ok;
    logic              out_of_range;
    logic              accept;
    logic [N_W-1:0]    n_in;

    assign accept = start && !busy;
    assign n_in   = (req.req_type[1:0] == KIND_WEEKS)
                  ? ((N_W'(req.amount) << 3) - N_W'(req.amount))
                  : N_W'(req.amount);

    assign kind    = op_reg[1:0];
    assign sub     = op_reg[2];
    assign p       = year_reg - YEAR_W'(1);
    assign p_mul   = 27'(p) * 27'd5243;
    assign q100    = p_mul[26:19];
    assign p365    = 23'(p) * 23'd365;
    assign y12     = (18'(year_reg) * 18'd12) + 18'(mon_reg) - 18'd1;
    assign t_mul   = 31'(acc_reg[16:2]) * 31'd43691;
    assign q12     = t_mul[30:17];
    assign day_ofs = 10'(days_before(mon_reg, lpin_reg)) + 10'(day_reg) - 10'd1;
    assign ml_in   = month_len(mon_reg, lpin_reg);
    assign ml_res  = month_len(rm_reg, leap_reg);

    assign date_ok = (year_reg >= YEAR_W'(1)) && (year_reg <= YEAR_W'(YEAR_LIMIT))
                  && (mon_reg >= MONTH_JAN) && (mon_reg <= MONTH_DEC)
                  && (day_reg != 5'd0) && (day_reg <= ml_in);

    always_comb
    begin
        case (kind)
            KIND_DAYS, KIND_WEEKS:
                out_of_range = acc_reg[ACC_W-1] || (acc_reg > SERIAL_LAST);
            KIND_MONTHS:
                out_of_range = (acc_reg < MONTH_INDEX_MIN) || (acc_reg >= MONTH_INDEX_END);
            default:
                out_of_range = (acc_reg < YEAR_MIN_S) || (acc_reg > YEAR_LIMIT_S);
        endcase
    end

    always_comb
    begin
        alu_ctl.subtract = 1'b0;
        alu_ctl.operand  = '0;
        case (state_reg)
            S_SER:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        alu_ctl.operand = ACC_W'(p >> 2);
                    end
                    4'd1:
                    begin
                        alu_ctl.subtract = 1'b1;
                        alu_ctl.operand  = ACC_W'(q100);
                    end
                    4'd2:
                    begin
                        alu_ctl.operand = ACC_W'(q100 >> 2);
                    end
                    default:
                    begin
                        alu_ctl.operand = ACC_W'(day_ofs);
                    end
                endcase
            end
            S_ADDN:
            begin
                alu_ctl.subtract = sub;
                alu_ctl.operand  = ACC_W'(n_reg);
            end
            S_MDIV:
            begin
                alu_ctl.subtract = 1'b1;
                alu_ctl.operand  = ACC_W'((18'(qt_reg) << 3) + (18'(qt_reg) << 2));
            end
            S_SPLIT:
            begin
                alu_ctl.subtract = 1'b1;
                alu_ctl.operand  = ACC_W'(split_div(step_reg));
            end
            S_MSCAN:
            begin
                alu_ctl.subtract = 1'b1;
                alu_ctl.operand  = ACC_W'(ml_res);
            end
            default:
            begin
                alu_ctl.subtract = 1'b0;
                alu_ctl.operand  = '0;
            end
        endcase
    end

    cdas_alu u_alu (
        .acc (acc_reg),
        .ctl (alu_ctl),
        .sum (alu_sum)
    );

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        qt_next     = qt_reg;
        ry_next     = ry_reg;
        rm_next     = rm_reg;
        rd_next     = rd_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!date_ok || (n_reg == '0))
                begin
                    status_next = date_ok ? STATUS_OK : STATUS_BAD_DATE;
                    ry_next     = year_reg;
                    rm_next     = mon_reg;
                    rd_next     = day_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    case (kind)
                        KIND_DAYS, KIND_WEEKS:
                        begin
                            acc_next   = $signed(ACC_W'(p365));
                            step_next  = 4'd0;
                            state_next = S_SER;
                        end
                        KIND_MONTHS:
                        begin
                            acc_next   = $signed(ACC_W'(y12));
                            state_next = S_ADDN;
                        end
                        default:
                        begin
                            acc_next   = $signed(ACC_W'(year_reg));
                            state_next = S_ADDN;
                        end
                    endcase
                end
            end
            S_SER:
            begin
                acc_next = alu_sum;
                if (step_reg == SER_LAST)
                begin
                    step_next  = 4'd0;
                    state_next = S_ADDN;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_ADDN:
            begin
                acc_next   = alu_sum;
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                if (out_of_range)
                begin
                    status_next = STATUS_RANGE;
                    ry_next     = year_reg;
                    rm_next     = mon_reg;
                    rd_next     = day_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    case (kind)
                        KIND_DAYS, KIND_WEEKS:
                        begin
                            ry_next    = YEAR_W'(1);
                            step_next  = 4'd0;
                            state_next = S_SPLIT;
                        end
                        KIND_MONTHS:
                        begin
                            qt_next    = q12;
                            state_next = S_MDIV;
                        end
                        default:
                        begin
                            ry_next    = acc_reg[YEAR_W-1:0];
                            rm_next    = mon_reg;
                            rd_next    = day_reg;
                            state_next = S_LEAPW;
                        end
                    endcase
                end
            end
            S_MDIV:
            begin
                acc_next   = alu_sum;
                ry_next    = qt_reg;
                rm_next    = alu_sum[3:0] + 4'd1;
                rd_next    = day_reg;
                state_next = S_LEAPW;
            end
            S_SPLIT:
            begin
                if (!alu_sum[ACC_W-1])
                begin
                    acc_next = alu_sum;
                    ry_next  = ry_reg + split_wt(step_reg);
                end
                if (step_reg == SPLIT_LAST)
                begin
                    step_next  = 4'd0;
                    rm_next    = MONTH_JAN;
                    state_next = S_LEAPW;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_LEAPW:
            begin
                state_next = kind[1] ? S_CLAMP : S_MSCAN;
            end
            S_MSCAN:
            begin
                if ((rm_reg != MONTH_DEC) && !alu_sum[ACC_W-1])
                begin
                    acc_next = alu_sum;
                    rm_next  = rm_reg + 4'd1;
                end
                else
                begin
                    rd_next    = acc_reg[4:0] + 5'd1;
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                if (rd_reg > ml_res)
                begin
                    rd_next = ml_res;
                end
                status_next = STATUS_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.req_type;
            day_reg  <= req.day_in;
            mon_reg  <= req.month_in;
            year_reg <= req.year_in;
            n_reg    <= n_in;
            lpin_reg <= is_leap(req.year_in);
        end
        acc_reg    <= acc_next;
        qt_reg     <= qt_next;
        ry_reg     <= ry_next;
        rm_reg     <= rm_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
        leap_reg   <= is_leap(ry_reg);
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign rsp.day_out   = rd_reg;
    assign rsp.month_out = rm_reg;
    assign rsp.year_out  = ry_reg;
    assign rsp.status    = status_reg;

    `CDAS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `CDAS_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
    `CDAS_ASSERT_IMPL(a_ok_date, clk, rst_n, done && (rsp.status == STATUS_OK), (rsp.month_out >= MONTH_JAN) && (rsp.month_out <= MONTH_DEC) && (rsp.day_out != 5'd0))
    `CDAS_ASSERT_IMPL(a_split_nonneg, clk, rst_n, (state_reg == S_SPLIT) || (state_reg == S_MSCAN), !acc_reg[ACC_W-1])

endmodule
